>>> sv/assert_macros.svh
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property under clock and reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> sv/ptd_pkg.sv
// Package: types, constants and codes of the trial-division block.
package ptd_pkg;
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned LenWidth = 13;
  localparam int unsigned PrimeWidth = 32;
  localparam int unsigned CandWidth = 64;
  localparam int unsigned IdxWidth = 12;

  typedef enum logic [1:0] {
    VERDICT_LOADED    = 2'd0,
    VERDICT_NOT_PRIME = 2'd1,
    VERDICT_PRIME     = 2'd2,
    VERDICT_SHORT     = 2'd3
  } verdict_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } command_e;

  localparam logic [0:0] RegTableLength = 1'b0;

  typedef struct packed {
    logic                  command;
    logic [IdxWidth-1:0]   entry_index;
    logic [PrimeWidth-1:0] entry_prime;
    logic [CandWidth-1:0]  candidate;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            verdict;
    logic [PrimeWidth-1:0] factor_found;
  } out_item_t;

  // Work item passed from front to back.
  typedef struct packed {
    logic                  is_load;
    logic                  trivial;
    logic [IdxWidth-1:0]   entry_index;
    logic [PrimeWidth-1:0] entry_prime;
    logic [CandWidth-1:0]  candidate;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_DIV, ST_OUT
  } back_state_e;
endpackage

>>> sv/ptd_ram.sv
// Generic RAM with one write port and one registered read port.
module ptd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/ptd_front.sv
// Front end: accept items, classify them and queue them for the back end.
module ptd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ptd_pkg::in_item_t in_item_i,
  output logic            job_valid_o,
  input  logic            job_take_i,
  output ptd_pkg::job_t   job_o
);
  // Two-entry queue.
  ptd_pkg::job_t job_q [2];
  logic [1:0] count_q, count_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;
  ptd_pkg::job_t job_new;

  // Classify the incoming item.
  always_comb begin
    job_new.is_load     = (in_item_i.command == ptd_pkg::CMD_LOAD);
    job_new.trivial     = (in_item_i.candidate[ptd_pkg::CandWidth-1:1] == '0);
    job_new.entry_index = in_item_i.entry_index;
    job_new.entry_prime = in_item_i.entry_prime;
    job_new.candidate   = in_item_i.candidate;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (count_q != 2'd0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = job_q[rd_q];

  // Advance pointers and count.
  always_comb begin
    count_d = count_q + {1'b0, push} - {1'b0, pop};
    rd_d    = rd_q ^ pop;
    wr_d    = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
    end
  end

  // Store payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      job_q[wr_q] <= job_new;
    end
  end
endmodule

>>> sv/ptd_divider.sv
// Iterative 64-by-32 remainder unit, one quotient bit per cycle.
module ptd_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic        zero_rem_o
);
  logic [63:0] dvd_q, dvd_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] shifted;

  // Shift-subtract step; hold the remainder once all 64 bits are in.
  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    shifted = {rem_q[31:0], dvd_q[63]};
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 7'd64) begin
        busy_d = 1'b0;
        cnt_d  = 7'd0;
      end else begin
        dvd_d = {dvd_q[62:0], 1'b0};
        if (shifted >= {1'b0, dsr_q}) begin
          rem_d = shifted - {1'b0, dsr_q};
        end else begin
          rem_d = shifted;
        end
        cnt_d = cnt_q + 7'd1;
      end
    end
  end

  assign done_o     = busy_q && (cnt_q == 7'd64);
  assign zero_rem_o = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end
endmodule

>>> sv/ptd_back.sv
// Back end: table store, table walk and result register.
module ptd_back #(
  parameter int unsigned TableDepth = ptd_pkg::TableDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ptd_pkg::LenWidth-1:0] table_length_i,
  input  logic                         job_valid_i,
  output logic                         job_take_o,
  input  ptd_pkg::job_t                job_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ptd_pkg::out_item_t           out_item_o
);
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  ptd_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [63:0]      cand_q, cand_d;
  ptd_pkg::out_item_t res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      rdata;
  logic [63:0]      square_q;
  logic [31:0]      prime_q;
  logic             div_start, div_done, div_zero;
  logic [CntW-1:0]  len_clip;
  logic             read_q;
  logic [63:0]      square_c;
  logic [31:0]      prime_hold_q;
  logic [63:0]      square_hold_q;

  // Clip table length to depth.
  always_comb begin
    if ({{(32-ptd_pkg::LenWidth){1'b0}}, table_length_i} > 32'(TableDepth)) begin
      len_clip = CntW'(TableDepth);
    end else begin
      len_clip = CntW'(table_length_i);
    end
  end

  assign we    = (state_q == ptd_pkg::ST_IDLE) && job_valid_i && !out_valid_q
                 && job_i.is_load
                 && ({20'd0, job_i.entry_index} < 32'(TableDepth));
  assign waddr = AddrW'(job_i.entry_index);
  assign raddr = idx_q[AddrW-1:0];

  ptd_ram #(.Width(32), .Depth(TableDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (job_i.entry_prime),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ptd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cand_q),
    .divisor_i  (prime_q),
    .done_o     (div_done),
    .zero_rem_o (div_zero)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (job_valid_i && !out_valid_q) begin
          if (job_i.is_load || job_i.trivial) state_d = ptd_pkg::ST_OUT;
          else                                state_d = ptd_pkg::ST_READ;
        end
      end
      ptd_pkg::ST_READ: begin
        if (idx_q >= limit_q) state_d = ptd_pkg::ST_OUT;
        else                  state_d = ptd_pkg::ST_CHECK;
      end
      ptd_pkg::ST_CHECK: begin
        if (square_q > cand_q)    state_d = ptd_pkg::ST_OUT;
        else if (prime_q == '0)   state_d = ptd_pkg::ST_READ;
        else                      state_d = ptd_pkg::ST_DIV;
      end
      ptd_pkg::ST_DIV: begin
        if (div_done) begin
          if (div_zero) state_d = ptd_pkg::ST_OUT;
          else          state_d = ptd_pkg::ST_READ;
        end
      end
      ptd_pkg::ST_OUT:  state_d = ptd_pkg::ST_IDLE;
      default:          state_d = ptd_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    idx_d       = idx_q;
    limit_d     = limit_q;
    cand_d      = cand_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_take_o  = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ptd_pkg::ST_IDLE: begin
        if (job_valid_i && !out_valid_q) begin
          job_take_o         = 1'b1;
          idx_d              = '0;
          limit_d            = len_clip;
          cand_d             = job_i.candidate;
          res_d.factor_found = '0;
          if (job_i.is_load)     res_d.verdict = ptd_pkg::VERDICT_LOADED;
          else if (job_i.trivial) res_d.verdict = ptd_pkg::VERDICT_NOT_PRIME;
          else                    res_d.verdict = ptd_pkg::VERDICT_SHORT;
        end
      end
      ptd_pkg::ST_READ: idx_d = idx_q;
      ptd_pkg::ST_CHECK: begin
        idx_d = idx_q + 1'b1;
        if (square_q > cand_q) res_d.verdict = ptd_pkg::VERDICT_PRIME;
        else if (prime_q != '0) div_start = 1'b1;
      end
      ptd_pkg::ST_DIV: begin
        if (div_done && div_zero) begin
          res_d.verdict      = ptd_pkg::VERDICT_NOT_PRIME;
          res_d.factor_found = prime_q;
        end
      end
      ptd_pkg::ST_OUT: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Capture the entry read in READ; square it in CHECK's stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) read_q <= 1'b0;
    else         read_q <= (state_q == ptd_pkg::ST_READ) && (idx_q < limit_q);
  end

  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    cand_q  <= cand_d;
    res_q   <= res_d;
  end

  // Prime and square registers: rdata valid in CHECK cycle, so multiply there.
  assign square_c = 64'(rdata) * 64'(rdata);
  always_comb begin
    prime_q  = read_q ? rdata : prime_hold_q;
    square_q = read_q ? square_c : square_hold_q;
  end
  always_ff @(posedge clk_i) begin
    if (read_q) begin
      prime_hold_q  <= rdata;
      square_hold_q <= square_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;
endmodule

>>> sv/prime_table_trial_division.sv
// Top level of the trial-division primality block.
// Usage:
//  - in channel (valid/stall) carries load and test items; out channel one
//    result item per input item, verdict and factor_found.
//  - APB register 0 (address 0) holds table_length, reset 0.
//  - A load, or a test of 0 or 1, goes from the queue straight to the OUT
//    state and the result register, with no table walk.
//  - Other tests walk the table. Each entry is read from the RAM (READ) and
//    compared by its square (CHECK); a zero entry goes on to the next read, a
//    square above the candidate ends the walk as prime, and any other entry
//    needs a pass through the shift-subtract remainder unit (DIV), which
//    thus sets most of the time that a test takes.
//  - A two-entry queue takes further items while the walk runs.
//  - The result register holds while out_stall_i is high; the walk of the
//    next item waits until it is taken.
//  - Reset empties the queue and clears the result valid; the table store
//    is not cleared and entries must be loaded before they are walked.
module prime_table_trial_division #(
  parameter int unsigned TableDepth = ptd_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptd_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [ptd_pkg::LenWidth-1:0] table_length_q;
  logic          job_valid, job_take;
  ptd_pkg::job_t job;

  // Register write and read.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (psel && penable && pwrite && paddr == {ptd_pkg::RegTableLength, 1'b0}) begin
      table_length_q <= pwdata[ptd_pkg::LenWidth-1:0];
    end
  end
  assign prdata = (paddr == {ptd_pkg::RegTableLength, 1'b0})
                  ? {{(32-ptd_pkg::LenWidth){1'b0}}, table_length_q} : '0;

  ptd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  ptd_back #(.TableDepth(TableDepth)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_length_i (table_length_q),
    .job_valid_i    (job_valid),
    .job_take_o     (job_take),
    .job_i          (job),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o)
  );
endmodule

>>> sv/ptd_checker.sv
// Port-level checker for the trial-division block, with its bind.
`include "assert_macros.svh"
module ptd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ptd_pkg::out_item_t out_item_o
);
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o),
              "result changed under stall")
  `ASSERT_CLK(a_factor_zero, clk_i, rst_ni,
              out_valid_o && out_item_o.verdict != ptd_pkg::VERDICT_NOT_PRIME
              |-> out_item_o.factor_found == '0,
              "factor without divisor")
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o,
                 "busy in reset")
endmodule

bind prime_table_trial_division ptd_checker u_ptd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

>>> verif/tb_prime_table_trial_division.sv
// Testbench: trial-division primality block checked against an in-bench table walk.
module tb_prime_table_trial_division;
  localparam int unsigned PrefixLen = 24;
  localparam int unsigned WatchLimit = 60000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  ptd_pkg::in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  ptd_pkg::out_item_t out_item_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Shadow of the block: table contents, written marks and length
  logic [ptd_pkg::PrimeWidth-1:0] shadow_table [ptd_pkg::TableDepth];
  bit shadow_written [ptd_pkg::TableDepth];
  logic [ptd_pkg::LenWidth-1:0] shadow_length;
  logic [ptd_pkg::PrimeWidth-1:0] prime_list [PrefixLen];

  ptd_pkg::out_item_t pending_results [$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit steady_flow;

  prime_table_trial_division uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly short, a few long; none while steady_flow is set
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Walk the shadow table; legal is cleared if an unwritten entry would be read
  function automatic ptd_pkg::out_item_t predict_verdict(ptd_pkg::in_item_t item,
                                                         output bit legal);
    ptd_pkg::out_item_t res;
    int unsigned count;
    logic [63:0] p;
    legal = 1'b1;
    res.verdict = ptd_pkg::VERDICT_LOADED;
    res.factor_found = '0;
    if (item.command == ptd_pkg::CMD_LOAD) return res;
    if (item.candidate < 64'd2) begin
      res.verdict = ptd_pkg::VERDICT_NOT_PRIME;
      return res;
    end
    count = (shadow_length > ptd_pkg::TableDepth) ? ptd_pkg::TableDepth : shadow_length;
    res.verdict = ptd_pkg::VERDICT_SHORT;
    for (int unsigned i = 0; i < count; i++) begin
      if (!shadow_written[i]) begin
        legal = 1'b0;
        return res;
      end
      p = {32'd0, shadow_table[i]};
      if (p * p > item.candidate) begin
        res.verdict = ptd_pkg::VERDICT_PRIME;
        return res;
      end
      if (p != 0 && item.candidate % p == 0) begin
        res.verdict = ptd_pkg::VERDICT_NOT_PRIME;
        res.factor_found = p[31:0];
        return res;
      end
    end
    return res;
  endfunction

  // Send one item, record its expected result on acceptance
  task automatic send_item(ptd_pkg::in_item_t item);
    bit legal;
    ptd_pkg::out_item_t res;
    int unsigned gap;
    res = predict_verdict(item, legal);
    // An illegal walk would read an unwritten entry: test an even number instead
    if (!legal) begin
      item.candidate = {item.candidate[63:2], 2'b10};
      res = predict_verdict(item, legal);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(res);
    if (item.command == ptd_pkg::CMD_LOAD) begin
      shadow_table[item.entry_index] = item.entry_prime;
      shadow_written[item.entry_index] = 1'b1;
    end
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_entry(int unsigned idx, logic [31:0] value);
    ptd_pkg::in_item_t item;
    item = '0;
    item.command = ptd_pkg::CMD_LOAD;
    item.entry_index = idx[ptd_pkg::IdxWidth-1:0];
    item.entry_prime = value;
    item.candidate = {$urandom, $urandom};
    send_item(item);
  endtask

  task automatic test_number(logic [63:0] cand);
    ptd_pkg::in_item_t item;
    item.command = ptd_pkg::CMD_TEST;
    item.entry_index = ptd_pkg::IdxWidth'($urandom);
    item.entry_prime = $urandom;
    item.candidate = cand;
    send_item(item);
  endtask

  // Lower valid, then let every result drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write table_length over APB while idle, then read it back
  task automatic set_length(logic [ptd_pkg::LenWidth-1:0] len);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {ptd_pkg::RegTableLength, 1'b0};
    pwdata <= 32'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow_length = len;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[ptd_pkg::LenWidth-1:0] !== len)
      $error("table_length readback: expected %0d actual %0d", len,
             prdata[ptd_pkg::LenWidth-1:0]);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    ptd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: verdict %0d factor_found %0d",
               out_item_o.verdict, out_item_o.factor_found);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.verdict !== want.verdict) begin
          $error("verdict: expected %0d actual %0d", want.verdict, out_item_o.verdict);
          fail_count++;
        end
        if (out_item_o.factor_found !== want.factor_found) begin
          $error("factor_found: expected %0d actual %0d",
                 want.factor_found, out_item_o.factor_found);
          fail_count++;
        end
      end
    end
  end

  // Stall the result side at random
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!steady_flow && $urandom_range(99) < 30) begin
        out_stall_i <= 1'b1;
        repeat (pick_gap()) @(posedge clk_i);
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_table_fill();
    int unsigned n;
    int unsigned cand;
    bit is_p;
    n = 0;
    cand = 2;
    while (n < PrefixLen) begin
      is_p = 1'b1;
      for (int unsigned d = 2; d * d <= cand; d++) if (cand % d == 0) is_p = 1'b0;
      if (is_p) begin
        prime_list[n] = cand;
        n++;
      end
      cand++;
    end
    for (int unsigned i = 0; i < PrefixLen; i++) load_entry(i, prime_list[i]);
    load_entry(ptd_pkg::TableDepth - 1, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    set_length(13'd0);
    test_number(64'd0);
    test_number(64'd1);
    test_number(64'd5);
    set_length(13'd1);
    test_number(64'd9);
    test_number(64'd8);
    set_length(ptd_pkg::LenWidth'(PrefixLen));
    test_number(64'd2);
    test_number(64'd4);
    test_number(64'd97);
    test_number(64'd89 * 64'd89);
    test_number(64'd101 * 64'd103);
    test_number(64'hFFFF_FFFF_FFFF_FFFF);
    test_number(64'hFFFF_FFFF_FFFF_FFC5);
    test_number(64'h8000_0000_0000_0000);
  endtask

  // Zero entry, entry one and an unsorted table, then restore
  task automatic test_odd_tables();
    set_length(ptd_pkg::LenWidth'(PrefixLen));
    load_entry(0, 32'd0);
    test_number(64'd15);
    test_number(64'd49);
    load_entry(1, 32'd1);
    test_number(64'd49);
    load_entry(0, 32'd7);
    load_entry(1, 32'd3);
    test_number(64'd21);
    load_entry(0, prime_list[0]);
    load_entry(1, prime_list[1]);
  endtask

  task automatic test_length_extremes();
    set_length(13'd4096);
    test_number(64'd1000);
    test_number(64'd35);
    set_length(13'h1FFF);
    test_number(64'd77);
    test_number({$urandom, $urandom});
    set_length(ptd_pkg::LenWidth'(PrefixLen));
  endtask

  task automatic test_random(int unsigned n);
    int unsigned roll;
    logic [63:0] cand;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        steady_flow = ($urandom_range(3) == 0);
        set_length(ptd_pkg::LenWidth'($urandom_range(PrefixLen, 1)));
      end
      roll = $urandom_range(99);
      if (roll < 15) begin
        load_entry($urandom_range(ptd_pkg::TableDepth - 1, PrefixLen), $urandom);
      end else if (roll < 20) begin
        roll = $urandom_range(PrefixLen - 1);
        load_entry(roll, prime_list[roll]);
      end else begin
        roll = $urandom_range(99);
        if (roll < 5) cand = 64'($urandom_range(1));
        else if (roll < 35) cand = 64'(prime_list[$urandom_range(PrefixLen - 1)]) *
                                   64'(prime_list[$urandom_range(PrefixLen - 1)]) *
                                   64'($urandom_range(50, 1));
        else if (roll < 65) cand = 64'($urandom_range(20000, 2));
        else cand = {$urandom, $urandom};
        test_number(cand);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    fail_count = 0;
    quiet_cycles = 0;
    steady_flow = 1'b0;
    shadow_length = '0;
    for (int i = 0; i < ptd_pkg::TableDepth; i++) shadow_written[i] = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_directed();
    test_odd_tables();
    test_length_extremes();
    test_random(90);

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
